// ----- hdl/bfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lane arithmetic for the box filter downsampler.
// No dependencies; every other file imports this package.
package bfd_pkg;

  localparam int MAX_SOURCE_WIDTH  = 2048;
  localparam int MAX_SOURCE_HEIGHT = 4096;
  localparam int LINE_DEPTH        = MAX_SOURCE_WIDTH / 2;
  localparam int IDX_BITS          = $clog2(LINE_DEPTH);
  localparam int SRC_W_BITS        = 12;
  localparam int SRC_H_BITS        = 13;
  localparam int COL_BITS          = 11;
  localparam int ROW_BITS          = 12;
  localparam int LANE_BITS         = 12;
  localparam int SUM_BITS          = 3 * LANE_BITS;
  localparam int CHAN_BITS         = 8;
  localparam int PADDR_BITS        = 4;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_FORMAT = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_TWO   = 2'd1,
    MODE_FOUR  = 2'd2,
    MODE_NONE3 = 2'd3
  } ds_mode_t;

  typedef enum logic [1:0] {
    FMT_XRGB    = 2'd0,
    FMT_XRGB_LE = 2'd1,
    FMT_ZERO2   = 2'd2,
    FMT_ZERO3   = 2'd3
  } pix_format_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic [COL_BITS-1:0]  out_column;
    logic [ROW_BITS-1:0]  out_row;
    logic                 frame_last;
  } result_t;

  typedef struct packed {
    ds_mode_t              mode;
    pix_format_t           format;
    logic [SRC_W_BITS-1:0] width;
    logic [SRC_H_BITS-1:0] height;
  } cfg_t;

  function automatic logic [SUM_BITS-1:0] lane_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] b);
    logic [LANE_BITS-1:0] s0;
    logic [LANE_BITS-1:0] s1;
    logic [LANE_BITS-1:0] s2;
    s0 = a[LANE_BITS-1:0] + b[LANE_BITS-1:0];
    s1 = a[2*LANE_BITS-1:LANE_BITS] + b[2*LANE_BITS-1:LANE_BITS];
    s2 = a[3*LANE_BITS-1:2*LANE_BITS] + b[3*LANE_BITS-1:2*LANE_BITS];
    return {s2, s1, s0};
  endfunction

endpackage

// ----- hdl/bfd_accum.sv -----
`timescale 1ns / 1ps
// Pixel decode, position counters, horizontal sum and the line sum memory.
// Uses bfd_pkg for types, sizes and the lane adder.
module bfd_accum import bfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 accept,
  input  logic [31:0]          pixel_word,
  input  logic                 frame_start,
  output logic                 res_valid,
  output result_t              res
);

  logic [COL_BITS-1:0] col_cnt;
  logic [ROW_BITS-1:0] row_cnt;
  logic [SUM_BITS-1:0] hsum;

  logic [SUM_BITS-1:0] line_mem [LINE_DEPTH];
  logic [SUM_BITS-1:0] rd_data;

  logic                s1_wr;
  logic                s1_res;
  logic                s1_first;
  logic                s1_fwd;
  logic [SUM_BITS-1:0] s1_fwd_data;
  logic [SUM_BITS-1:0] s1_hsum;
  logic [IDX_BITS-1:0] s1_idx;
  logic [COL_BITS-1:0] s1_oc;
  logic [ROW_BITS-1:0] s1_orow;
  logic                s1_last;
  logic [1:0]          s1_sh;
  logic [SUM_BITS-1:0] s1_total;

  logic [SRC_W_BITS-1:0] w_eff;
  logic [SRC_H_BITS-1:0] h_eff;
  logic [1:0]            sh;
  logic [1:0]            blk_mask;
  logic [SRC_W_BITS-1:0] w_trunc;
  logic [SRC_H_BITS-1:0] h_trunc;
  logic [SRC_W_BITS-1:0] ow_m1;
  logic [SRC_H_BITS-1:0] oh_m1;
  logic [COL_BITS-1:0]   col;
  logic [ROW_BITS-1:0]   row;
  logic [SUM_BITS-1:0]   hbase;
  logic [SUM_BITS-1:0]   hadd;
  logic [SUM_BITS-1:0]   pix;
  logic [CHAN_BITS-1:0]  r_dec;
  logic [CHAN_BITS-1:0]  g_dec;
  logic [CHAN_BITS-1:0]  b_dec;
  logic                  in_range;
  logic                  blk_end;
  logic                  row_first;
  logic                  row_last;
  logic [COL_BITS-1:0]   oc;
  logic [ROW_BITS-1:0]   orow;
  logic                  last;
  logic [IDX_BITS-1:0]   idx;
  logic [SRC_W_BITS-1:0] col_inc;
  logic [SRC_H_BITS-1:0] row_inc;
  logic [COL_BITS-1:0]   col_next;
  logic [ROW_BITS-1:0]   row_next;
  logic [SUM_BITS-1:0]   hsum_next;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = SRC_W_BITS'(1);
    end else if (cfg.width > SRC_W_BITS'(MAX_SOURCE_WIDTH)) begin
      w_eff = SRC_W_BITS'(MAX_SOURCE_WIDTH);
    end else begin
      w_eff = cfg.width;
    end
    if (cfg.height == '0) begin
      h_eff = SRC_H_BITS'(1);
    end else if (cfg.height > SRC_H_BITS'(MAX_SOURCE_HEIGHT)) begin
      h_eff = SRC_H_BITS'(MAX_SOURCE_HEIGHT);
    end else begin
      h_eff = cfg.height;
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_TWO: begin
        sh       = 2'd1;
        blk_mask = 2'b01;
      end
      MODE_FOUR: begin
        sh       = 2'd2;
        blk_mask = 2'b11;
      end
      default: begin
        sh       = 2'd0;
        blk_mask = 2'b00;
      end
    endcase
  end

  always_comb begin
    case (cfg.format)
      FMT_XRGB: begin
        r_dec = pixel_word[15:8];
        g_dec = pixel_word[23:16];
        b_dec = pixel_word[31:24];
      end
      FMT_XRGB_LE: begin
        r_dec = pixel_word[23:16];
        g_dec = pixel_word[15:8];
        b_dec = pixel_word[7:0];
      end
      default: begin
        r_dec = '0;
        g_dec = '0;
        b_dec = '0;
      end
    endcase
  end

  always_comb begin
    col       = frame_start ? '0 : col_cnt;
    row       = frame_start ? '0 : row_cnt;
    hbase     = frame_start ? '0 : hsum;
    w_trunc   = w_eff & ~{{(SRC_W_BITS-2){1'b0}}, blk_mask};
    h_trunc   = h_eff & ~{{(SRC_H_BITS-2){1'b0}}, blk_mask};
    ow_m1     = (w_eff >> sh) - SRC_W_BITS'(1);
    oh_m1     = (h_eff >> sh) - SRC_H_BITS'(1);
    in_range  = ({1'b0, col} < w_trunc) && ({1'b0, row} < h_trunc);
    blk_end   = (col[1:0] & blk_mask) == blk_mask;
    row_first = (row[1:0] & blk_mask) == 2'b00;
    row_last  = (row[1:0] & blk_mask) == blk_mask;
    oc        = col >> sh;
    orow      = row >> sh;
    last      = ({1'b0, oc} == ow_m1) && ({1'b0, orow} == oh_m1);
    idx       = oc[IDX_BITS-1:0];
    pix       = {{(LANE_BITS-CHAN_BITS){1'b0}}, b_dec,
                 {(LANE_BITS-CHAN_BITS){1'b0}}, g_dec,
                 {(LANE_BITS-CHAN_BITS){1'b0}}, r_dec};
    hadd      = lane_add(hbase, pix);
    if (!in_range) begin
      hsum_next = hbase;
    end else if (blk_end) begin
      hsum_next = '0;
    end else begin
      hsum_next = hadd;
    end
    col_inc  = {1'b0, col} + SRC_W_BITS'(1);
    row_inc  = {1'b0, row} + SRC_H_BITS'(1);
    col_next = col_inc[COL_BITS-1:0];
    row_next = row;
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
    end
  end

  always_comb begin
    s1_total = s1_first ? s1_hsum
                        : lane_add(s1_fwd ? s1_fwd_data : rd_data, s1_hsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      hsum    <= '0;
      s1_wr   <= 1'b0;
      s1_res  <= 1'b0;
    end else begin
      s1_wr  <= accept && in_range && blk_end;
      s1_res <= accept && in_range && blk_end && row_last;
      if (accept) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
        hsum    <= hsum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first    <= row_first;
    s1_fwd      <= s1_wr && (s1_idx == idx);
    s1_fwd_data <= s1_total;
    s1_hsum     <= hadd;
    s1_idx      <= idx;
    s1_oc       <= oc;
    s1_orow     <= orow;
    s1_last     <= last;
    s1_sh       <= sh;
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      line_mem[s1_idx] <= s1_total;
    end
    rd_data <= line_mem[idx];
  end

  logic [LANE_BITS-1:0] avg_r;
  logic [LANE_BITS-1:0] avg_g;
  logic [LANE_BITS-1:0] avg_b;

  always_comb begin
    avg_r          = s1_total[LANE_BITS-1:0] >> {s1_sh, 1'b0};
    avg_g          = s1_total[2*LANE_BITS-1:LANE_BITS] >> {s1_sh, 1'b0};
    avg_b          = s1_total[3*LANE_BITS-1:2*LANE_BITS] >> {s1_sh, 1'b0};
    res_valid      = s1_res;
    res.red        = avg_r[CHAN_BITS-1:0];
    res.green      = avg_g[CHAN_BITS-1:0];
    res.blue       = avg_b[CHAN_BITS-1:0];
    res.out_column = s1_oc;
    res.out_row    = s1_orow;
    res.frame_last = s1_last;
  end

endmodule

// ----- hdl/bfd_out_queue.sv -----
`timescale 1ns / 1ps
// Small result queue that decouples the output handshake from the pipeline.
// Uses bfd_pkg for the result type and queue depth.
module bfd_out_queue import bfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  result_t              push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output result_t              head,
  output logic [QPTR_BITS:0]   count
);

  result_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic                 do_pop;

  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      count <= count + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/box_filter_downsampler.sv -----
`timescale 1ns / 1ps
// Top level of the box filter downsampler: register port, accumulator, result queue.
// Depends on bfd_pkg, bfd_accum and bfd_out_queue.
//
// Source pixels enter on the in channel (in_valid, in_ready) in raster order,
// with frame_start marking the first pixel of a frame. Each item is decoded
// to red, green and blue and summed over 1x1, 2x2 or 4x4 blocks. When the
// last pixel of a block arrives, the block average leaves on the out channel
// (out_valid, out_ready) with its output column, row and a frame_last flag.
// Partial blocks at the right and bottom edges give no item.
// The block takes one item per cycle while in_ready is high. Once its last pixel is
// accepted, a result passes the line sum memory read, then the add, write back and
// queueing of the result, before it appears on out. Partial block sums live in a
// single-port-per-side line memory of 1024 entries of 36 bits; a write to an entry
// read by the next item is forwarded. A four-entry result queue absorbs stalls of
// the receiver; when it and the item in flight fill it, in_ready drops until
// out_ready takes a result. The user must write the registers over the APB port
// only while no item is in flight; the block does not enforce this. A synchronous
// reset empties the pipeline and queue, restores the register defaults and zeros the
// counters; no memory clearing pass is needed.
module box_filter_downsampler import bfd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_BITS-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [31:0]             pixel_word,
  input  logic                    frame_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAN_BITS-1:0]    red,
  output logic [CHAN_BITS-1:0]    green,
  output logic [CHAN_BITS-1:0]    blue,
  output logic [COL_BITS-1:0]     out_column,
  output logic [ROW_BITS-1:0]     out_row,
  output logic                    frame_last
);

  cfg_t                cfg;
  reg_index_t          reg_sel;
  logic                cfg_wr;
  logic                accept;
  logic                res_valid;
  result_t             res;
  result_t             head;
  logic [QPTR_BITS:0]  q_count;
  logic [QPTR_BITS:0]  load;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[PADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_NONE;
      cfg.format <= FMT_XRGB;
      cfg.width  <= SRC_W_BITS'(MAX_SOURCE_WIDTH);
      cfg.height <= SRC_H_BITS'(MAX_SOURCE_HEIGHT);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MODE:   cfg.mode   <= ds_mode_t'(pwdata[1:0]);
        REG_FORMAT: cfg.format <= pix_format_t'(pwdata[1:0]);
        REG_WIDTH:  cfg.width  <= pwdata[SRC_W_BITS-1:0];
        REG_HEIGHT: cfg.height <= pwdata[SRC_H_BITS-1:0];
        default:    cfg.mode   <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:   prdata = {30'd0, cfg.mode};
      REG_FORMAT: prdata = {30'd0, cfg.format};
      REG_WIDTH:  prdata = {{(32-SRC_W_BITS){1'b0}}, cfg.width};
      REG_HEIGHT: prdata = {{(32-SRC_H_BITS){1'b0}}, cfg.height};
      default:    prdata = '0;
    endcase
  end

  assign load     = q_count + (QPTR_BITS+1)'(res_valid);
  assign in_ready = load <= (QPTR_BITS+1)'(QUEUE_DEPTH - 1);
  assign accept   = in_valid && in_ready;

  bfd_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .pixel_word  (pixel_word),
    .frame_start (frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  bfd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign red        = head.red;
  assign green      = head.green;
  assign blue       = head.blue;
  assign out_column = head.out_column;
  assign out_row    = head.out_row;
  assign frame_last = head.frame_last;

endmodule

// ----- hdl/bfd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the box filter downsampler, bound to the top level.
// Depends on bfd_pkg for field widths.
module bfd_checker import bfd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHAN_BITS-1:0] red,
  input logic [COL_BITS-1:0]  out_column,
  input logic [ROW_BITS-1:0]  out_row
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result pending right after reset.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while no result is waiting.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result appeared without an item accepted two cycles before.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(red) && $stable(out_column) && $stable(out_row))
    else $error("Stalled result changed or vanished.");

endmodule

bind box_filter_downsampler bfd_checker u_bfd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .red        (red),
  .out_column (out_column),
  .out_row    (out_row)
);
